[src/segment_pair_min_distance_sq_macros.svh]
// Assertion macros for the segment pair distance block.
// Used by the checker module; expects clk_i and rst_ni in scope.
`ifndef SEGMENT_PAIR_MIN_DISTANCE_SQ_MACROS_SVH
`define SEGMENT_PAIR_MIN_DISTANCE_SQ_MACROS_SVH
// check outside reset
`define SEGD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// check at every edge, reset included
`define SEGD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`endif

[src/segd_pkg.sv]
// Package for the segment pair distance block: widths, constants, codes, types.
// No dependencies.
package segd_pkg;

  localparam int COORD_BITS  = 20;
  localparam int FRAC_BITS   = 24;
  localparam int NFIELD_IN   = 12;
  localparam int IN_W        = NFIELD_IN * COORD_BITS;
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int DIST_W      = 42;
  localparam int CODE_W      = 3;
  localparam int OUT_W       = DIST_W + CODE_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  localparam int DW      = COORD_BITS + 1;
  localparam int DOT_W   = 2 * DW + 2;
  localparam int NUM_W   = 2 * DOT_W + 1;
  localparam int DEN_W   = NUM_W - 1;
  localparam int QUO_W   = FRAC_BITS + 1;
  localparam int CC_W    = DW + FRAC_BITS + 2;
  localparam int MUL_W   = (DOT_W > CC_W) ? DOT_W : CC_W;
  localparam int MUL_PW  = 2 * MUL_W;
  localparam int SUM_W   = 2 * CC_W;
  localparam int SH_W    = SUM_W - 2 * FRAC_BITS;
  localparam int CMP_W   = (SH_W > DIST_W) ? SH_W : DIST_W;
  localparam int NSTAGE  = 15 + FRAC_BITS;
  localparam int VEC_N   = 10 + FRAC_BITS;
  localparam int CODE_N  = 8 + FRAC_BITS;
  localparam int DOT_N   = 5;

  localparam logic [DIST_W-1:0] DIST_MAX = 42'd3298528591875;

  typedef enum logic [CODE_W-1:0] {
    CASE_BOTH_PT  = 3'd0,
    CASE_P_PT     = 3'd1,
    CASE_Q_PT     = 3'd2,
    CASE_GENERAL  = 3'd3,
    CASE_PARALLEL = 3'd4
  } case_code_e;

  typedef struct packed {
    logic [2:0][DW-1:0] u;
    logic [2:0][DW-1:0] v;
    logic [2:0][DW-1:0] w;
  } vec_t;

  typedef struct packed {
    logic signed [DOT_W-1:0] a;
    logic signed [DOT_W-1:0] b;
    logic signed [DOT_W-1:0] c;
    logic signed [DOT_W-1:0] d;
    logic signed [DOT_W-1:0] e;
  } dot_t;

endpackage

[src/segment_pair_min_distance_sq.sv]
// Squared minimum distance between two 3D segments, fully pipelined.
// Depends on segd_pkg, segd_mul and segd_div.
//
// Usage:
//   Slave stream: one beat carries both segments, twelve signed Q10.10
//   coordinates p0 p1 q0 q1 (x y z each), COORD_BITS bits per field.
//   Master stream: one beat per input beat with dist_sq (units of 2^-20,
//   saturating) and case_code.
//   Pipeline from input beat to output beat: dot products, the wide
//   products of the dot products, case selection, one stage per quotient
//   bit in the two dividers, then the reconstruction, squares and the
//   final sum.
//   Throughput: one beat per cycle while output beats are taken.
//   Reset clears all stage valid bits; no beat is in flight afterwards.
//   Stall: while an output beat waits, the whole pipeline holds and
//   s_axis_tready is low; as soon as the beat is taken the pipeline
//   advances, and an input beat is accepted in that same cycle.
module segment_pair_min_distance_sq (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // p0_x p0_y p0_z p1_x p1_y p1_z q0_x q0_y q0_z q1_x q1_y q1_z
  input  logic [segd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // dist_sq case_code
  output logic [segd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  localparam int CB = segd_pkg::COORD_BITS;
  localparam int F  = segd_pkg::FRAC_BITS;
  localparam int DW = segd_pkg::DW;
  localparam int NW = segd_pkg::NUM_W;

  logic                          en;
  logic [segd_pkg::NSTAGE-1:0]   vld_q;

  segd_pkg::vec_t                vec_d;
  segd_pkg::vec_t                vec_q  [segd_pkg::VEC_N];
  segd_pkg::dot_t                dot_d;
  segd_pkg::dot_t                dot_q  [segd_pkg::DOT_N];
  segd_pkg::case_code_e          code_d;
  segd_pkg::case_code_e          code_q [segd_pkg::CODE_N];

  logic signed [2*DW-1:0]        prod_q [5][3];

  logic signed [segd_pkg::MUL_PW-1:0] ac, bb, be, cd, ae, bd;
  logic signed [NW-1:0]          den_q, sng_q, tng_q;
  logic signed [NW-1:0]          sn_d, sd_d, tn_d, td_d;
  logic signed [NW-1:0]          sn1_q, sd1_q, tn1_q, td1_q;
  logic [segd_pkg::DEN_W-1:0]    snum_d, sden_d, tnum_d, tden_d;
  logic [segd_pkg::DEN_W-1:0]    snum_q, sden_q, tnum_q, tden_q;
  logic [segd_pkg::QUO_W-1:0]    sf, tf;

  logic signed [segd_pkg::CC_W-1:0]   sfu_q [3];
  logic signed [segd_pkg::CC_W-1:0]   tfv_q [3];
  logic signed [segd_pkg::CC_W-1:0]   cc_q  [3];
  logic signed [segd_pkg::MUL_PW-1:0] sq    [3];
  logic [segd_pkg::SUM_W-1:0]         sum_q;
  logic [segd_pkg::CMP_W-1:0]         sh;
  logic [segd_pkg::DIST_W-1:0]        dist_q;
  segd_pkg::case_code_e               code_out_q;

  assign en            = !vld_q[segd_pkg::NSTAGE-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[segd_pkg::NSTAGE-1];
  assign m_axis_tdata  = segd_pkg::OUT_TDATA_W'({code_out_q, dist_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[segd_pkg::NSTAGE-2:0], s_axis_tvalid};
    end
  end

  // difference vectors
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vec_d.u[k] = DW'($signed(s_axis_tdata[(3+k)*CB +: CB]))
                 - DW'($signed(s_axis_tdata[k*CB +: CB]));
      vec_d.v[k] = DW'($signed(s_axis_tdata[(9+k)*CB +: CB]))
                 - DW'($signed(s_axis_tdata[(6+k)*CB +: CB]));
      vec_d.w[k] = DW'($signed(s_axis_tdata[k*CB +: CB]))
                 - DW'($signed(s_axis_tdata[(6+k)*CB +: CB]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vec_q[0] <= vec_d;
      for (int i = 1; i < segd_pkg::VEC_N; i++) begin
        vec_q[i] <= vec_q[i-1];
      end
      for (int k = 0; k < 3; k++) begin
        prod_q[0][k] <= $signed(vec_q[0].u[k]) * $signed(vec_q[0].u[k]);
        prod_q[1][k] <= $signed(vec_q[0].u[k]) * $signed(vec_q[0].v[k]);
        prod_q[2][k] <= $signed(vec_q[0].v[k]) * $signed(vec_q[0].v[k]);
        prod_q[3][k] <= $signed(vec_q[0].u[k]) * $signed(vec_q[0].w[k]);
        prod_q[4][k] <= $signed(vec_q[0].v[k]) * $signed(vec_q[0].w[k]);
      end
      dot_q[0] <= dot_d;
      for (int i = 1; i < segd_pkg::DOT_N; i++) begin
        dot_q[i] <= dot_q[i-1];
      end
    end
  end

  always_comb begin
    dot_d.a = segd_pkg::DOT_W'(prod_q[0][0]) + segd_pkg::DOT_W'(prod_q[0][1])
            + segd_pkg::DOT_W'(prod_q[0][2]);
    dot_d.b = segd_pkg::DOT_W'(prod_q[1][0]) + segd_pkg::DOT_W'(prod_q[1][1])
            + segd_pkg::DOT_W'(prod_q[1][2]);
    dot_d.c = segd_pkg::DOT_W'(prod_q[2][0]) + segd_pkg::DOT_W'(prod_q[2][1])
            + segd_pkg::DOT_W'(prod_q[2][2]);
    dot_d.d = segd_pkg::DOT_W'(prod_q[3][0]) + segd_pkg::DOT_W'(prod_q[3][1])
            + segd_pkg::DOT_W'(prod_q[3][2]);
    dot_d.e = segd_pkg::DOT_W'(prod_q[4][0]) + segd_pkg::DOT_W'(prod_q[4][1])
            + segd_pkg::DOT_W'(prod_q[4][2]);
  end

  segd_mul u_mul_ac (
    .clk_i, .en_i(en),
    .a_i(segd_pkg::MUL_W'($signed(dot_q[0].a))),
    .b_i(segd_pkg::MUL_W'($signed(dot_q[0].c))), .prod_o(ac)
  );
  segd_mul u_mul_bb (
    .clk_i, .en_i(en),
    .a_i(segd_pkg::MUL_W'($signed(dot_q[0].b))),
    .b_i(segd_pkg::MUL_W'($signed(dot_q[0].b))), .prod_o(bb)
  );
  segd_mul u_mul_be (
    .clk_i, .en_i(en),
    .a_i(segd_pkg::MUL_W'($signed(dot_q[0].b))),
    .b_i(segd_pkg::MUL_W'($signed(dot_q[0].e))), .prod_o(be)
  );
  segd_mul u_mul_cd (
    .clk_i, .en_i(en),
    .a_i(segd_pkg::MUL_W'($signed(dot_q[0].c))),
    .b_i(segd_pkg::MUL_W'($signed(dot_q[0].d))), .prod_o(cd)
  );
  segd_mul u_mul_ae (
    .clk_i, .en_i(en),
    .a_i(segd_pkg::MUL_W'($signed(dot_q[0].a))),
    .b_i(segd_pkg::MUL_W'($signed(dot_q[0].e))), .prod_o(ae)
  );
  segd_mul u_mul_bd (
    .clk_i, .en_i(en),
    .a_i(segd_pkg::MUL_W'($signed(dot_q[0].b))),
    .b_i(segd_pkg::MUL_W'($signed(dot_q[0].d))), .prod_o(bd)
  );

  // first clamp of s, choice of t ratio
  always_comb begin
    logic signed [NW-1:0] a_x, b_x, c_x, d_x, e_x;
    a_x = NW'($signed(dot_q[3].a));
    b_x = NW'($signed(dot_q[3].b));
    c_x = NW'($signed(dot_q[3].c));
    d_x = NW'($signed(dot_q[3].d));
    e_x = NW'($signed(dot_q[3].e));
    sn_d   = '0;
    sd_d   = NW'(1);
    tn_d   = '0;
    td_d   = NW'(1);
    code_d = segd_pkg::CASE_BOTH_PT;
    if (a_x == '0 && c_x == '0) begin
      code_d = segd_pkg::CASE_BOTH_PT;
    end else if (a_x == '0) begin
      code_d = segd_pkg::CASE_P_PT;
      td_d   = c_x;
      if (e_x < 0) begin
        tn_d = '0;
      end else if (e_x > c_x) begin
        tn_d = c_x;
      end else begin
        tn_d = e_x;
      end
    end else if (c_x == '0) begin
      code_d = segd_pkg::CASE_Q_PT;
      sd_d   = a_x;
      if (-d_x < 0) begin
        sn_d = '0;
      end else if (-d_x > a_x) begin
        sn_d = a_x;
      end else begin
        sn_d = -d_x;
      end
    end else if (den_q > 0) begin
      code_d = segd_pkg::CASE_GENERAL;
      sd_d   = den_q;
      if (sng_q < 0) begin
        sn_d = '0;
        tn_d = e_x;
        td_d = c_x;
      end else if (sng_q > den_q) begin
        sn_d = den_q;
        tn_d = e_x + b_x;
        td_d = c_x;
      end else begin
        sn_d = sng_q;
        tn_d = tng_q;
        td_d = den_q;
      end
    end else begin
      code_d = segd_pkg::CASE_PARALLEL;
      tn_d   = e_x;
      td_d   = c_x;
    end
  end

  // clamp of t, with s recomputed against the clamped t
  always_comb begin
    logic signed [NW-1:0] a_x, m_x, sn, sd, tn;
    logic                 redo;
    a_x  = NW'($signed(dot_q[4].a));
    sn   = sn1_q;
    sd   = sd1_q;
    tn   = tn1_q;
    redo = 1'b0;
    m_x  = '0;
    if (code_q[0] == segd_pkg::CASE_GENERAL || code_q[0] == segd_pkg::CASE_PARALLEL) begin
      if (tn1_q < 0) begin
        tn   = '0;
        m_x  = -NW'($signed(dot_q[4].d));
        redo = 1'b1;
      end else if (tn1_q > td1_q) begin
        tn   = td1_q;
        m_x  = NW'($signed(dot_q[4].b)) - NW'($signed(dot_q[4].d));
        redo = 1'b1;
      end
    end
    if (redo) begin
      if (m_x < 0) begin
        sn = '0;
      end else if (m_x > a_x) begin
        sn = sd1_q;
      end else begin
        sn = m_x;
        sd = a_x;
      end
    end
    snum_d = sn[segd_pkg::DEN_W-1:0];
    sden_d = sd[segd_pkg::DEN_W-1:0];
    tnum_d = tn[segd_pkg::DEN_W-1:0];
    tden_d = td1_q[segd_pkg::DEN_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      den_q  <= NW'($signed(ac[2*segd_pkg::DOT_W-1:0]))
              - NW'($signed(bb[2*segd_pkg::DOT_W-1:0]));
      sng_q  <= NW'($signed(be[2*segd_pkg::DOT_W-1:0]))
              - NW'($signed(cd[2*segd_pkg::DOT_W-1:0]));
      tng_q  <= NW'($signed(ae[2*segd_pkg::DOT_W-1:0]))
              - NW'($signed(bd[2*segd_pkg::DOT_W-1:0]));
      sn1_q  <= sn_d;
      sd1_q  <= sd_d;
      tn1_q  <= tn_d;
      td1_q  <= td_d;
      snum_q <= snum_d;
      sden_q <= sden_d;
      tnum_q <= tnum_d;
      tden_q <= tden_d;
      code_q[0] <= code_d;
      for (int i = 1; i < segd_pkg::CODE_N; i++) begin
        code_q[i] <= code_q[i-1];
      end
    end
  end

  segd_div u_div_s (
    .clk_i, .en_i(en), .num_i(snum_q), .den_i(sden_q), .quo_o(sf)
  );
  segd_div u_div_t (
    .clk_i, .en_i(en), .num_i(tnum_q), .den_i(tden_q), .quo_o(tf)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sfu_q[k] <= $signed({1'b0, sf}) * $signed(vec_q[8+F].u[k]);
        tfv_q[k] <= $signed({1'b0, tf}) * $signed(vec_q[8+F].v[k]);
        cc_q[k]  <= (segd_pkg::CC_W'($signed(vec_q[9+F].w[k])) <<< F)
                  + sfu_q[k] - tfv_q[k];
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_sq
    segd_mul u_mul_sq (
      .clk_i, .en_i(en),
      .a_i(segd_pkg::MUL_W'(cc_q[k])),
      .b_i(segd_pkg::MUL_W'(cc_q[k])), .prod_o(sq[k])
    );
  end

  assign sh = segd_pkg::CMP_W'(sum_q >> (2 * F));

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q <= sq[0][segd_pkg::SUM_W-1:0] + sq[1][segd_pkg::SUM_W-1:0]
             + sq[2][segd_pkg::SUM_W-1:0];
      if (sh > segd_pkg::CMP_W'(segd_pkg::DIST_MAX)) begin
        dist_q <= segd_pkg::DIST_MAX;
      end else begin
        dist_q <= sh[segd_pkg::DIST_W-1:0];
      end
      code_out_q <= code_q[segd_pkg::CODE_N-1];
    end
  end

endmodule

[src/segd_mul.sv]
// Two-stage signed multiplier built from four half-width partial products.
// Depends on segd_pkg for operand widths.
module segd_mul (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [segd_pkg::MUL_W-1:0]  a_i,
  input  logic signed [segd_pkg::MUL_W-1:0]  b_i,
  output logic signed [segd_pkg::MUL_PW-1:0] prod_o
);

  localparam int LO_W = (segd_pkg::MUL_W + 1) / 2;
  localparam int HI_W = segd_pkg::MUL_W - LO_W;
  localparam int PW   = segd_pkg::MUL_PW;

  logic signed [LO_W:0]   al, bl;
  logic signed [HI_W-1:0] ah, bh;
  logic signed [2*LO_W+1:0]      ll_q;
  logic signed [LO_W+HI_W:0]     lh_q, hl_q;
  logic signed [2*HI_W-1:0]      hh_q;
  logic signed [PW-1:0]          prod_d, prod_q;

  assign al = $signed({1'b0, a_i[LO_W-1:0]});
  assign bl = $signed({1'b0, b_i[LO_W-1:0]});
  assign ah = $signed(a_i[segd_pkg::MUL_W-1:LO_W]);
  assign bh = $signed(b_i[segd_pkg::MUL_W-1:LO_W]);

  assign prod_d = (PW'(hh_q) <<< (2 * LO_W)) + (PW'(lh_q) <<< LO_W)
                + (PW'(hl_q) <<< LO_W) + PW'(ll_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q   <= al * bl;
      lh_q   <= al * bh;
      hl_q   <= ah * bl;
      hh_q   <= ah * bh;
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

[src/segd_div.sv]
// Pipelined restoring divider, one quotient bit per stage, for num <= den.
// Depends on segd_pkg for widths; quotient has FRAC_BITS fraction bits.
module segd_div (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [segd_pkg::DEN_W-1:0]      num_i,
  input  logic [segd_pkg::DEN_W-1:0]      den_i,
  output logic [segd_pkg::QUO_W-1:0]      quo_o
);

  localparam int REM_W = segd_pkg::DEN_W + 1;
  localparam int QW    = segd_pkg::QUO_W;

  logic [REM_W-1:0]          rem_q [QW];
  logic [REM_W-1:0]          rem_d [QW];
  logic [segd_pkg::DEN_W-1:0] den_q [QW];
  logic [QW-1:0]             quo_q [QW];
  logic [QW-1:0]             quo_d [QW];

  always_comb begin
    logic [REM_W-1:0] r_in;
    logic [REM_W-1:0] d_in;
    logic [QW-1:0]    q_in;
    logic             ge;
    for (int j = 0; j < QW; j++) begin
      if (j == 0) begin
        r_in = REM_W'(num_i);
        d_in = REM_W'(den_i);
        q_in = '0;
      end else begin
        r_in = rem_q[j-1] << 1;
        d_in = REM_W'(den_q[j-1]);
        q_in = quo_q[j-1];
      end
      ge       = (r_in >= d_in);
      rem_d[j] = ge ? (r_in - d_in) : r_in;
      quo_d[j] = q_in;
      if (ge) begin
        quo_d[j][QW-1-j] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < QW; j++) begin
        rem_q[j] <= rem_d[j];
        quo_q[j] <= quo_d[j];
        if (j == 0) begin
          den_q[j] <= den_i;
        end else begin
          den_q[j] <= den_q[j-1];
        end
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

[src/segd_chk.sv]
// Port-level checker for the segment pair distance block, bound to the top.
// Depends on segd_pkg and segment_pair_min_distance_sq_macros.svh.
`include "segment_pair_min_distance_sq_macros.svh"

module segd_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [segd_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [segd_pkg::CODE_W-1:0] out_code;
  logic [segd_pkg::DIST_W-1:0] out_dist;

  assign out_code = m_axis_tdata[segd_pkg::DIST_W +: segd_pkg::CODE_W];
  assign out_dist = m_axis_tdata[segd_pkg::DIST_W-1:0];

  `SEGD_ASSERT_RST(a_rst_idle, !rst_ni |-> !m_axis_tvalid, "valid during reset")
  `SEGD_ASSERT(a_hold_vld, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "beat dropped")
  `SEGD_ASSERT(a_hold_data, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "beat changed")
  `SEGD_ASSERT(a_code_rng, m_axis_tvalid |-> out_code <= segd_pkg::CASE_PARALLEL, "bad case code")
  `SEGD_ASSERT(a_dist_rng, m_axis_tvalid |-> out_dist <= segd_pkg::DIST_MAX, "distance above bound")

endmodule

bind segment_pair_min_distance_sq segd_chk u_segd_chk (.*);

[test/tb_segment_pair_min_distance_sq.sv]
// Self-checking bench for segment_pair_min_distance_sq: streams segment pairs,
// predicts squared distance and case code per beat, and compares in order.
// Depends on segd_pkg and the block under test.
`timescale 1ns / 1ps

module tb_segment_pair_min_distance_sq;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 2 * (15 + segd_pkg::FRAC_BITS) + 10;
  localparam int CB           = segd_pkg::COORD_BITS;
  localparam int FB           = segd_pkg::FRAC_BITS;
  localparam int DW_OUT       = segd_pkg::DIST_W;
  localparam int CW_OUT       = segd_pkg::CODE_W;

  typedef logic signed [CB-1:0] coord_t;
  typedef logic signed [255:0] big_t;

  typedef struct {
    coord_t c [12];
  } seg_pair_t;

  typedef struct {
    logic [DW_OUT-1:0]    dist_sq;
    segd_pkg::case_code_e code;
  } dist_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [segd_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [segd_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  dist_result_t expected_q[$];
  int  fail_cnt = 0;
  int  cycle_cnt = 0;
  bit  idle_on = 1'b1;
  bit  hold_req = 1'b0;
  bit  hold_on = 1'b0;

  segment_pair_min_distance_sq DUT (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic big_t clamp_to(big_t v, big_t hi, big_t over);
    if (v < 0) return 0;
    if (v > hi) return over;
    return v;
  endfunction

  function automatic dist_result_t predict_distance(seg_pair_t sp);
    big_t u[3], v[3], w[3];
    big_t a, b, c, d, e, sn, sd, tn, td, den, m, sf, tf, cc, sum;
    dist_result_t r;
    for (int k = 0; k < 3; k++) begin
      u[k] = big_t'(sp.c[3+k]) - big_t'(sp.c[k]);
      v[k] = big_t'(sp.c[9+k]) - big_t'(sp.c[6+k]);
      w[k] = big_t'(sp.c[k]) - big_t'(sp.c[6+k]);
    end
    a = u[0]*u[0] + u[1]*u[1] + u[2]*u[2];
    b = u[0]*v[0] + u[1]*v[1] + u[2]*v[2];
    c = v[0]*v[0] + v[1]*v[1] + v[2]*v[2];
    d = u[0]*w[0] + u[1]*w[1] + u[2]*w[2];
    e = v[0]*w[0] + v[1]*w[1] + v[2]*w[2];
    sn = 0; sd = 1; tn = 0; td = 1;
    if (a == 0 && c == 0) begin
      r.code = segd_pkg::CASE_BOTH_PT;
    end else if (a == 0) begin
      r.code = segd_pkg::CASE_P_PT;
      tn = clamp_to(e, c, c); td = c;
    end else if (c == 0) begin
      r.code = segd_pkg::CASE_Q_PT;
      sn = clamp_to(-d, a, a); sd = a;
    end else begin
      den = a*c - b*b;
      if (den > 0) begin
        r.code = segd_pkg::CASE_GENERAL;
        sn = b*e - c*d;
        sd = den;
        if (sn < 0) begin
          sn = 0; tn = e; td = c;
        end else if (sn > den) begin
          sn = den; tn = e + b; td = c;
        end else begin
          tn = a*e - b*d; td = den;
        end
      end else begin
        r.code = segd_pkg::CASE_PARALLEL;
        tn = e; td = c;
      end
      if (tn < 0) begin
        m = -d; tn = 0;
        if (m < 0) sn = 0;
        else if (m > a) sn = sd;
        else begin
          sn = m; sd = a;
        end
      end else if (tn > td) begin
        m = b - d; tn = td;
        if (m < 0) sn = 0;
        else if (m > a) sn = sd;
        else begin
          sn = m; sd = a;
        end
      end
    end
    sf = (sd == 0) ? 0 : (sn <<< FB) / sd;
    tf = (td == 0) ? 0 : (tn <<< FB) / td;
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      cc = (w[k] <<< FB) + sf*u[k] - tf*v[k];
      sum = sum + cc*cc;
    end
    sum = sum >>> (2*FB);
    r.dist_sq = (sum > big_t'(segd_pkg::DIST_MAX)) ? segd_pkg::DIST_MAX
                                                   : sum[DW_OUT-1:0];
    return r;
  endfunction

  task automatic send_pair(seg_pair_t sp);
    logic [segd_pkg::IN_TDATA_W-1:0] beat;
    int gap;
    beat = '0;
    for (int k = 0; k < 12; k++) beat[k*CB +: CB] = sp.c[k];
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= beat;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_q.push_back(predict_distance(sp));
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // hold the receiver off for a long stretch on request
  initial begin
    forever begin
      wait (hold_req);
      hold_req = 1'b0;
      hold_on  = 1'b1;
      repeat (300) @(posedge clk_i);
      hold_on  = 1'b0;
    end
  end

  // drive ready and check each output beat against the oldest prediction
  initial begin
    int idle_left;
    dist_result_t want;
    idle_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          $error("dist_sq: unexpected beat, actual %0d", m_axis_tdata[DW_OUT-1:0]);
          fail_cnt++;
        end else begin
          want = expected_q.pop_front();
          if (m_axis_tdata[DW_OUT-1:0] !== want.dist_sq) begin
            $error("dist_sq: expected %0d actual %0d", want.dist_sq,
                   m_axis_tdata[DW_OUT-1:0]);
            fail_cnt++;
          end
          if (m_axis_tdata[DW_OUT +: CW_OUT] !== want.code) begin
            $error("case_code: expected %0d actual %0d", want.code,
                   m_axis_tdata[DW_OUT +: CW_OUT]);
            fail_cnt++;
          end
        end
      end
      if (hold_on) begin
        m_axis_tready <= 1'b0;
      end else if (idle_left > 0) begin
        idle_left--;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        idle_left = $urandom_range(1, 5) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom());
      1: return coord_t'($urandom_range(0, 2047)) - coord_t'(1024);
      default: return coord_t'($urandom_range(0, 31)) - coord_t'(16);
    endcase
  endfunction

  function automatic seg_pair_t rand_pair();
    seg_pair_t sp;
    int mode, kind, kx;
    mode = $urandom_range(0, 2);
    kind = $urandom_range(0, 9);
    for (int k = 0; k < 12; k++) sp.c[k] = rand_coord(mode);
    case (kind)
      0: for (int k = 0; k < 3; k++) sp.c[3+k] = sp.c[k];
      1: for (int k = 0; k < 3; k++) sp.c[9+k] = sp.c[6+k];
      2: for (int k = 0; k < 3; k++) begin
           sp.c[3+k] = sp.c[k];
           sp.c[9+k] = sp.c[6+k];
         end
      3, 4: begin
        // Q direction is a small multiple of P direction
        kx = $urandom_range(0, 4) - 2;
        if (kx == 0) kx = 1;
        for (int k = 0; k < 3; k++) begin
          sp.c[k]   = rand_coord(2);
          sp.c[3+k] = sp.c[k] + rand_coord(2);
          sp.c[6+k] = rand_coord(1);
          sp.c[9+k] = sp.c[6+k] + coord_t'(kx) * (sp.c[3+k] - sp.c[k]);
        end
      end
      5: for (int k = 0; k < 3; k++) sp.c[6+k] = sp.c[3+k];
      default: ;
    endcase
    return sp;
  endfunction

  function automatic seg_pair_t fill_pair(coord_t p0, coord_t p1, coord_t q0,
                                          coord_t q1);
    seg_pair_t sp;
    for (int k = 0; k < 3; k++) begin
      sp.c[k] = p0; sp.c[3+k] = p1; sp.c[6+k] = q0; sp.c[9+k] = q1;
    end
    return sp;
  endfunction

  task automatic test_extremes();
    coord_t mx, mn;
    mx = {1'b0, {(CB-1){1'b1}}};
    mn = {1'b1, {(CB-1){1'b0}}};
    send_pair(fill_pair(mn, mn, mx, mx));
    send_pair(fill_pair(mx, mx, mn, mn));
    send_pair(fill_pair(mn, mx, mn, mx));
    send_pair(fill_pair(mn, mx, mx, mn));
    send_pair(fill_pair(mx, mn, mn, mx));
    send_pair(fill_pair(0, 0, 0, 0));
    send_pair(fill_pair(-1, -1, 1, 1));
    send_pair(fill_pair(mn, mx, 0, 1));
  endtask

  task automatic test_degenerate();
    seg_pair_t sp;
    send_pair(fill_pair(5, 5, 9, 9));
    send_pair(fill_pair(5, 5, -100, 100));
    send_pair(fill_pair(-100, 100, 5, 5));
    send_pair(fill_pair(300, 300, -100, 100));
    send_pair(fill_pair(-100, 100, -700, -700));
    sp = fill_pair(0, 0, 0, 0);
    sp.c[3] = 1000; sp.c[7] = -500; sp.c[10] = 500;
    send_pair(sp);
    sp.c[6] = 2000; sp.c[9] = 2000;
    send_pair(sp);
    sp.c[6] = -2000; sp.c[9] = -2000;
    send_pair(sp);
  endtask

  task automatic test_parallel();
    send_pair(fill_pair(0, 100, 50, 150));
    send_pair(fill_pair(0, 100, 200, 300));
    send_pair(fill_pair(0, 100, -300, -200));
    send_pair(fill_pair(0, 100, 150, 50));
    send_pair(fill_pair(0, 100, 0, 100));
  endtask

  task automatic test_random(int n);
    repeat (n) send_pair(rand_pair());
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (120) send_pair(rand_pair());
  endtask

  task automatic test_drain_pause();
    s_axis_tvalid <= 1'b0;
    wait (expected_q.size() == 0);
    @(posedge clk_i);
    repeat (50) send_pair(rand_pair());
  endtask

  task automatic test_no_idle(int n);
    idle_on = 1'b0;
    repeat (n) send_pair(rand_pair());
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_degenerate();
    test_parallel();
    test_random(700);
    test_backpressure();
    test_drain_pause();
    test_random(250);
    test_no_idle(200);
    s_axis_tvalid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
